/* sv/sts_pkg.sv */
// Shared types, phase codes and next-state functions of the siren tone sequencer.
// No dependencies; used by every module of the block.
package sts_pkg;

   localparam int PERIOD_BITS = 16;
   localparam int PHASE_BITS  = 5;
   localparam int TICK_BITS   = 11;
   localparam int STEP_BITS   = 6;
   localparam int CMD_BITS    = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int RUN_EXTRA   = 4;

   localparam logic [PHASE_BITS-1:0] PH_IDLE      = 5'd0;
   localparam logic [PHASE_BITS-1:0] PH_STEADY    = 5'd1;
   localparam logic [PHASE_BITS-1:0] PH_RINGING   = 5'd2;
   localparam logic [PHASE_BITS-1:0] PH_CHOP_ON   = 5'd3;
   localparam logic [PHASE_BITS-1:0] PH_CHOP_OFF  = 5'd4;
   localparam logic [PHASE_BITS-1:0] PH_CHOPS_ON  = 5'd5;
   localparam logic [PHASE_BITS-1:0] PH_CHOPS_OFF = 5'd6;
   localparam logic [PHASE_BITS-1:0] PH_UP        = 5'd7;
   localparam logic [PHASE_BITS-1:0] PH_UP_WAIT   = 5'd8;
   localparam logic [PHASE_BITS-1:0] PH_UP_NEXT   = 5'd9;
   localparam logic [PHASE_BITS-1:0] PH_DOWN      = 5'd10;
   localparam logic [PHASE_BITS-1:0] PH_DOWN_WAIT = 5'd11;
   localparam logic [PHASE_BITS-1:0] PH_DOWN_NEXT = 5'd12;
   localparam logic [PHASE_BITS-1:0] PH_CONF      = 5'd13;
   localparam logic [PHASE_BITS-1:0] PH_CONF_GAP  = 5'd14;
   localparam logic [PHASE_BITS-1:0] PH_CONF_BEEP = 5'd15;
   localparam logic [PHASE_BITS-1:0] PH_SHORT     = 5'd16;
   localparam logic [PHASE_BITS-1:0] PH_HALF      = 5'd17;
   localparam logic [PHASE_BITS-1:0] PH_LONG      = 5'd18;
   localparam logic [PHASE_BITS-1:0] PH_BEEP_WAIT = 5'd19;
   localparam logic [PHASE_BITS-1:0] PH_STOP      = 5'd20;

   localparam logic [CMD_BITS-1:0] CMD_STOP       = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_STEADY     = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_CHOP_LONG  = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_CHOP_SHORT = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_SWEEP_UP   = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_SWEEP_DOWN = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_CONFIRM    = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_SHORT      = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_HALF       = 4'd8;
   localparam logic [CMD_BITS-1:0] CMD_LONG       = 4'd9;

   localparam logic [CSR_IDX_BITS-1:0] REG_FIXED_PERIOD = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SWEEP_START  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SWEEP_STEP   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SWEEP_COUNT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_SWEEP_DWELL  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHORT_TICKS  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_HALF_TICKS   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_LONG_TICKS   = 3'd7;

   localparam logic [TICK_BITS-1:0] CHOP_LONG_TICKS  = 11'd1500;
   localparam logic [TICK_BITS-1:0] CHOP_SHORT_TICKS = 11'd500;
   localparam logic [STEP_BITS-1:0] CONFIRM_REPEATS  = 6'd7;

   typedef struct packed {
      logic [15:0] fixed_tone_period;
      logic [15:0] sweep_start;
      logic [7:0]  sweep_step;
      logic [5:0]  sweep_count;
      logic [10:0] sweep_dwell;
      logic [10:0] short_beep_ticks;
      logic [10:0] half_beep_ticks;
      logic [10:0] long_beep_ticks;
   } sts_cfg_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]  phase;
      logic [TICK_BITS-1:0]   timeout_left;
      logic [STEP_BITS-1:0]   steps_left;
      logic [PERIOD_BITS-1:0] period_now;
      logic                   amp_enabled;
   } sts_state_type;

   function automatic logic is_transient(input logic [PHASE_BITS-1:0] p);
      return p == PH_STEADY || p == PH_UP || p == PH_UP_NEXT || p == PH_DOWN ||
             p == PH_DOWN_NEXT || p == PH_CONF || p == PH_SHORT ||
             p == PH_HALF || p == PH_LONG || p == PH_STOP;
   endfunction

   function automatic logic [PHASE_BITS-1:0] entry_phase(input logic [CMD_BITS-1:0] cmd);
      logic [PHASE_BITS-1:0] p;
      case (cmd)
         CMD_STOP:       p = PH_STOP;
         CMD_STEADY:     p = PH_STEADY;
         CMD_CHOP_LONG:  p = PH_CHOP_ON;
         CMD_CHOP_SHORT: p = PH_CHOPS_ON;
         CMD_SWEEP_UP:   p = PH_UP;
         CMD_SWEEP_DOWN: p = PH_DOWN;
         CMD_CONFIRM:    p = PH_CONF;
         CMD_SHORT:      p = PH_SHORT;
         CMD_HALF:       p = PH_HALF;
         CMD_LONG:       p = PH_LONG;
         default:        p = PH_STOP;
      endcase
      return p;
   endfunction

   function automatic sts_state_type sweep_next(input sts_state_type s, input sts_cfg_type c,
                                                input logic up,
                                                input logic [PHASE_BITS-1:0] wait_phase);
      sts_state_type n;
      logic [PERIOD_BITS-1:0] step;
      n = s;
      step = PERIOD_BITS'(c.sweep_step);
      if (s.steps_left != '0) begin
         n.period_now = up ? s.period_now + step : s.period_now - step;
      end else begin
         n.steps_left = c.sweep_count;
         n.period_now = c.sweep_start[PERIOD_BITS-1:0];
      end
      n.timeout_left = c.sweep_dwell;
      n.phase = wait_phase;
      return n;
   endfunction

   function automatic sts_state_type run_once(input sts_state_type s, input sts_cfg_type c);
      sts_state_type n;
      logic t0;
      n = s;
      t0 = (s.timeout_left == '0);
      case (s.phase)
         PH_IDLE, PH_RINGING: begin
         end
         PH_STEADY: begin
            n.period_now = c.fixed_tone_period[PERIOD_BITS-1:0];
            n.amp_enabled = 1'b1;
            n.phase = PH_RINGING;
         end
         PH_CHOP_ON: begin
            if (t0) begin
               n.period_now = c.fixed_tone_period[PERIOD_BITS-1:0];
               n.amp_enabled = 1'b1;
               n.phase = PH_CHOP_OFF;
               n.timeout_left = CHOP_LONG_TICKS;
            end
         end
         PH_CHOP_OFF: begin
            if (t0) begin
               n.amp_enabled = 1'b0;
               n.phase = PH_CHOP_ON;
               n.timeout_left = CHOP_SHORT_TICKS;
            end
         end
         PH_CHOPS_ON: begin
            if (t0) begin
               n.period_now = c.fixed_tone_period[PERIOD_BITS-1:0];
               n.amp_enabled = 1'b1;
               n.phase = PH_CHOPS_OFF;
               n.timeout_left = CHOP_SHORT_TICKS;
            end
         end
         PH_CHOPS_OFF: begin
            if (t0) begin
               n.amp_enabled = 1'b0;
               n.phase = PH_CHOPS_ON;
               n.timeout_left = CHOP_LONG_TICKS;
            end
         end
         PH_UP: begin
            n.steps_left = '0;
            n.amp_enabled = 1'b1;
            n.phase = PH_UP_NEXT;
         end
         PH_UP_WAIT: begin
            if (t0) begin
               if (s.steps_left != '0) n.steps_left = s.steps_left - 1'b1;
               n.phase = PH_UP_NEXT;
            end
         end
         PH_UP_NEXT: n = sweep_next(s, c, 1'b1, PH_UP_WAIT);
         PH_DOWN: begin
            n.steps_left = '0;
            n.amp_enabled = 1'b1;
            n.phase = PH_DOWN_NEXT;
         end
         PH_DOWN_WAIT: begin
            if (t0) begin
               if (s.steps_left != '0) n.steps_left = s.steps_left - 1'b1;
               n.phase = PH_DOWN_NEXT;
            end
         end
         PH_DOWN_NEXT: n = sweep_next(s, c, 1'b0, PH_DOWN_WAIT);
         PH_CONF: begin
            n.steps_left = CONFIRM_REPEATS;
            n.timeout_left = c.short_beep_ticks;
            n.amp_enabled = 1'b1;
            n.phase = PH_CONF_BEEP;
         end
         PH_CONF_GAP: begin
            if (t0) begin
               if (s.steps_left != '0) begin
                  n.steps_left = s.steps_left - 1'b1;
                  n.timeout_left = c.short_beep_ticks;
                  n.amp_enabled = 1'b1;
                  n.phase = PH_CONF_BEEP;
               end else begin
                  n.phase = PH_STOP;
               end
            end
         end
         PH_CONF_BEEP: begin
            if (t0) begin
               n.amp_enabled = 1'b0;
               n.phase = PH_CONF_GAP;
               n.timeout_left = c.short_beep_ticks;
            end
         end
         PH_SHORT: begin
            n.timeout_left = c.short_beep_ticks;
            n.amp_enabled = 1'b1;
            n.phase = PH_BEEP_WAIT;
         end
         PH_HALF: begin
            n.timeout_left = c.half_beep_ticks;
            n.amp_enabled = 1'b1;
            n.phase = PH_BEEP_WAIT;
         end
         PH_LONG: begin
            n.timeout_left = c.long_beep_ticks;
            n.amp_enabled = 1'b1;
            n.phase = PH_BEEP_WAIT;
         end
         PH_BEEP_WAIT: begin
            if (t0) n.phase = PH_STOP;
         end
         default: begin
            n.amp_enabled = 1'b0;
            n.phase = PH_IDLE;
         end
      endcase
      return n;
   endfunction

endpackage

/* sv/sts_csr.sv */
// Configuration register file of the siren tone sequencer.
// Depends on sts_pkg for the register indexes and the configuration struct.
module sts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sts_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sts_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output sts_pkg::sts_cfg_type             cfg
);
   import sts_pkg::*;

   sts_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FIXED_PERIOD: cfg_in.fixed_tone_period = csr_wdata;
            REG_SWEEP_START:  cfg_in.sweep_start = csr_wdata;
            REG_SWEEP_STEP:   cfg_in.sweep_step = csr_wdata[7:0];
            REG_SWEEP_COUNT:  cfg_in.sweep_count = csr_wdata[5:0];
            REG_SWEEP_DWELL:  cfg_in.sweep_dwell = csr_wdata[10:0];
            REG_SHORT_TICKS:  cfg_in.short_beep_ticks = csr_wdata[10:0];
            REG_HALF_TICKS:   cfg_in.half_beep_ticks = csr_wdata[10:0];
            REG_LONG_TICKS:   cfg_in.long_beep_ticks = csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_tone_period <= 16'd1250;
         cfg_ff.sweep_start <= 16'd1400;
         cfg_ff.sweep_step <= 8'd10;
         cfg_ff.sweep_count <= 6'd40;
         cfg_ff.sweep_dwell <= 11'd15;
         cfg_ff.short_beep_ticks <= 11'd200;
         cfg_ff.half_beep_ticks <= 11'd400;
         cfg_ff.long_beep_ticks <= 11'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/sts_step.sv */
// Next-state logic of the siren tone sequencer for one tick or command beat.
// Depends on sts_pkg for the phase functions and state struct.
module sts_step (
   input  sts_pkg::sts_state_type               cur,
   input  sts_pkg::sts_cfg_type                 cfg,
   input  logic                                 func,
   input  logic [sts_pkg::CMD_BITS-1:0]          command,
   output sts_pkg::sts_state_type               nxt
);
   import sts_pkg::*;

   sts_state_type s;

   always_comb begin
      s = cur;
      if (func) begin
         s.phase = entry_phase(command);
      end else if (cur.timeout_left != '0) begin
         s.timeout_left = cur.timeout_left - 1'b1;
      end
      s = run_once(s, cfg);
      for (int i = 0; i < RUN_EXTRA; i++) begin
         if (is_transient(s.phase)) s = run_once(s, cfg);
      end
      nxt = s;
   end

endmodule

/* sv/siren_tone_sequencer_unit.sv */
// Top level of the siren tone sequencer: input register, state update, result register.
// Depends on sts_pkg, sts_csr and sts_step.
//
//   port group | dir | handshake          | payload
//   req_       | in  | req_valid/stall    | func, command
//   rsp_       | out | rsp_valid/stall    | amp_on, tone_period, tone_high, active
//   csr_       | in  | csr_wr_en          | csr_index, csr_wdata
//
// One beat per clock unless stalled; beats pass the input, then the result register.
// The state update is one pass through sts_step between the two registers.
// Reset clears the state, the valid flags and loads the register defaults.
// req_stall rises only when the input register is full and the result is held.
module siren_tone_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [sts_pkg::CMD_BITS-1:0]      req_command,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_amp_on,
   output logic [15:0]                      rsp_tone_period,
   output logic [14:0]                      rsp_tone_high,
   output logic                             rsp_active,
   input  logic                             csr_wr_en,
   input  logic [sts_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sts_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import sts_pkg::*;

   sts_cfg_type   cfg;
   sts_state_type st_ff, st_nxt;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_func_ff;
   logic [CMD_BITS-1:0] s1_cmd_ff;
   logic                s1_adv, req_take;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        amp_ff, active_ff;
   logic [15:0] period_ff;
   logic [14:0] high_ff;

   sts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sts_step u_step (
      .cur     (st_ff),
      .cfg     (cfg),
      .func    (s1_func_ff),
      .command (s1_cmd_ff),
      .nxt     (st_nxt)
   );

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) st_ff <= st_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff <= req_func;
         s1_cmd_ff <= req_command;
      end
      if (s1_adv) begin
         amp_ff <= st_nxt.amp_enabled;
         period_ff <= 16'(st_nxt.period_now);
         high_ff <= 15'(st_nxt.period_now >> 1);
         active_ff <= (st_nxt.phase != PH_IDLE);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_amp_on      = amp_ff;
   assign rsp_tone_period = period_ff;
   assign rsp_tone_high   = high_ff;
   assign rsp_active      = active_ff;

`ifndef ASSERT_OFF
   a_settled: assert property (@(posedge clock) disable iff (reset)
      !is_transient(st_ff.phase))
      else $error("state register holds an unresolved entry phase");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_IDLE) |-> !st_ff.amp_enabled)
      else $error("amplifier enabled while idle");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with room downstream");
   a_adv_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced beat lost before result register");
   a_amp_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && amp_ff) |-> active_ff)
      else $error("result shows amplifier on while inactive");
`endif

endmodule

/* tb/sts_tone_check_pkg.sv */
// Result beat type and tone tracker class for the siren tone sequencer testbench.
// The tracker keeps its own copy of the sequencer state and registers and queues the expected tones.
// Depends on sts_pkg for phase, command and register codes.
package sts_tone_check_pkg;
   import sts_pkg::*;

   typedef struct packed {
      logic        amp_on;
      logic [15:0] tone_period;
      logic [14:0] tone_high;
      logic        active;
   } tone_beat_type;

   class tone_tracker;
      logic [15:0]            fixed_period;
      logic [15:0]            sweep_start;
      logic [7:0]             sweep_step;
      logic [5:0]             sweep_count;
      logic [10:0]            sweep_dwell;
      logic [10:0]            short_ticks;
      logic [10:0]            half_ticks;
      logic [10:0]            long_ticks;
      logic [PHASE_BITS-1:0]  phase;
      logic [TICK_BITS-1:0]   ticks_left;
      logic [STEP_BITS-1:0]   tones_left;
      logic [PERIOD_BITS-1:0] period;
      logic                   amp;
      tone_beat_type          expected_tones[$];
      int                     mismatches;

      function new();
         fixed_period = 16'd1250;
         sweep_start  = 16'd1400;
         sweep_step   = 8'd10;
         sweep_count  = 6'd40;
         sweep_dwell  = 11'd15;
         short_ticks  = 11'd200;
         half_ticks   = 11'd400;
         long_ticks   = 11'd1000;
         phase        = PH_IDLE;
         ticks_left   = '0;
         tones_left   = '0;
         period       = '0;
         amp          = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            REG_FIXED_PERIOD: fixed_period = v;
            REG_SWEEP_START:  sweep_start  = v;
            REG_SWEEP_STEP:   sweep_step   = v[7:0];
            REG_SWEEP_COUNT:  sweep_count  = v[5:0];
            REG_SWEEP_DWELL:  sweep_dwell  = v[10:0];
            REG_SHORT_TICKS:  short_ticks  = v[10:0];
            REG_HALF_TICKS:   half_ticks   = v[10:0];
            default:          long_ticks   = v[10:0];
         endcase
      endfunction

      function bit passes_through(logic [PHASE_BITS-1:0] p);
         case (p)
            PH_STEADY, PH_UP, PH_UP_NEXT, PH_DOWN, PH_DOWN_NEXT, PH_CONF,
            PH_SHORT, PH_HALF, PH_LONG, PH_STOP: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void load_tone(bit rising, logic [PHASE_BITS-1:0] hold);
         if (tones_left != '0) begin
            period = rising ? period + 16'(sweep_step) : period - 16'(sweep_step);
         end else begin
            tones_left = sweep_count;
            period     = sweep_start;
         end
         ticks_left = sweep_dwell;
         phase      = hold;
      endfunction

      function void run_phase();
         bit expired;
         expired = (ticks_left == '0);
         case (phase)
            PH_IDLE, PH_RINGING: begin
            end
            PH_STEADY: begin
               period = fixed_period;
               amp    = 1'b1;
               phase  = PH_RINGING;
            end
            PH_CHOP_ON: if (expired) begin
               period     = fixed_period;
               amp        = 1'b1;
               phase      = PH_CHOP_OFF;
               ticks_left = CHOP_LONG_TICKS;
            end
            PH_CHOP_OFF: if (expired) begin
               amp        = 1'b0;
               phase      = PH_CHOP_ON;
               ticks_left = CHOP_SHORT_TICKS;
            end
            PH_CHOPS_ON: if (expired) begin
               period     = fixed_period;
               amp        = 1'b1;
               phase      = PH_CHOPS_OFF;
               ticks_left = CHOP_SHORT_TICKS;
            end
            PH_CHOPS_OFF: if (expired) begin
               amp        = 1'b0;
               phase      = PH_CHOPS_ON;
               ticks_left = CHOP_LONG_TICKS;
            end
            PH_UP: begin
               tones_left = '0;
               amp        = 1'b1;
               phase      = PH_UP_NEXT;
            end
            PH_UP_WAIT: if (expired) begin
               if (tones_left != '0) tones_left = tones_left - 1'b1;
               phase = PH_UP_NEXT;
            end
            PH_UP_NEXT: load_tone(1'b1, PH_UP_WAIT);
            PH_DOWN: begin
               tones_left = '0;
               amp        = 1'b1;
               phase      = PH_DOWN_NEXT;
            end
            PH_DOWN_WAIT: if (expired) begin
               if (tones_left != '0) tones_left = tones_left - 1'b1;
               phase = PH_DOWN_NEXT;
            end
            PH_DOWN_NEXT: load_tone(1'b0, PH_DOWN_WAIT);
            PH_CONF: begin
               tones_left = CONFIRM_REPEATS;
               ticks_left = short_ticks;
               amp        = 1'b1;
               phase      = PH_CONF_BEEP;
            end
            PH_CONF_GAP: if (expired) begin
               if (tones_left != '0) begin
                  tones_left = tones_left - 1'b1;
                  ticks_left = short_ticks;
                  amp        = 1'b1;
                  phase      = PH_CONF_BEEP;
               end else begin
                  phase = PH_STOP;
               end
            end
            PH_CONF_BEEP: if (expired) begin
               amp        = 1'b0;
               phase      = PH_CONF_GAP;
               ticks_left = short_ticks;
            end
            PH_SHORT: begin
               ticks_left = short_ticks;
               amp        = 1'b1;
               phase      = PH_BEEP_WAIT;
            end
            PH_HALF: begin
               ticks_left = half_ticks;
               amp        = 1'b1;
               phase      = PH_BEEP_WAIT;
            end
            PH_LONG: begin
               ticks_left = long_ticks;
               amp        = 1'b1;
               phase      = PH_BEEP_WAIT;
            end
            PH_BEEP_WAIT: if (expired) phase = PH_STOP;
            default: begin
               amp   = 1'b0;
               phase = PH_IDLE;
            end
         endcase
      endfunction

      function void note_beat(logic func, logic [CMD_BITS-1:0] cmd);
         tone_beat_type t;
         int            extra;
         if (func) begin
            case (cmd)
               CMD_STEADY:     phase = PH_STEADY;
               CMD_CHOP_LONG:  phase = PH_CHOP_ON;
               CMD_CHOP_SHORT: phase = PH_CHOPS_ON;
               CMD_SWEEP_UP:   phase = PH_UP;
               CMD_SWEEP_DOWN: phase = PH_DOWN;
               CMD_CONFIRM:    phase = PH_CONF;
               CMD_SHORT:      phase = PH_SHORT;
               CMD_HALF:       phase = PH_HALF;
               CMD_LONG:       phase = PH_LONG;
               default:        phase = PH_STOP;
            endcase
         end else if (ticks_left != '0) begin
            ticks_left = ticks_left - 1'b1;
         end
         run_phase();
         extra = 0;
         while (extra < RUN_EXTRA && passes_through(phase)) begin
            run_phase();
            extra++;
         end
         t.amp_on      = amp;
         t.tone_period = period;
         t.tone_high   = period[15:1];
         t.active      = (phase != PH_IDLE);
         expected_tones.push_back(t);
      endfunction

      function void check_result(tone_beat_type got);
         tone_beat_type want;
         if (expected_tones.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: amp_on %0d period %0d high %0d active %0d",
                        got.amp_on, got.tone_period, got.tone_high, got.active);
            return;
         end
         want = expected_tones.pop_front();
         if (got.amp_on !== want.amp_on || got.tone_period !== want.tone_period ||
             got.tone_high !== want.tone_high || got.active !== want.active) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: amp_on %0d/%0d period %0d/%0d high %0d/%0d ",
                         "active %0d/%0d (expected/actual)"},
                        want.amp_on, got.amp_on, want.tone_period, got.tone_period,
                        want.tone_high, got.tone_high, want.active, got.active);
         end
      endfunction
   endclass

endpackage

/* tb/tb_siren_tone_sequencer_unit.sv */
// Top-level testbench of siren_tone_sequencer_unit: directed and random tick/command beats
// under several register settings and idling mixes, checked against the tone tracker.
// Depends on sts_pkg, sts_tone_check_pkg and the block's RTL.
module tb_siren_tone_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sts_pkg::*;
   import sts_tone_check_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_func    = 1'b0;
   logic [CMD_BITS-1:0]      req_command = '0;
   logic                     rsp_stall   = 1'b0;
   logic                     csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata   = '0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic                     rsp_amp_on;
   logic [15:0]              rsp_tone_period;
   logic [14:0]              rsp_tone_high;
   logic                     rsp_active;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int unsigned cycle_count   = 0;
   tone_tracker tracker       = new();

   always #5ns clock = ~clock;

   siren_tone_sequencer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_command     (req_command),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_amp_on      (rsp_amp_on),
      .rsp_tone_period (rsp_tone_period),
      .rsp_tone_high   (rsp_tone_high),
      .rsp_active      (rsp_active),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= !reset && ($urandom_range(0, 99) < stall_pct);
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_beat(req_func, req_command);
         if (rsp_valid && !rsp_stall)
            tracker.check_result('{rsp_amp_on, rsp_tone_period, rsp_tone_high, rsp_active});
      end
   end

   task automatic send_beat(input logic func, input logic [CMD_BITS-1:0] cmd);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_command <= cmd;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      tracker.set_reg(idx, v);
   endtask

   task automatic write_all(input logic [15:0] fixed, input logic [15:0] start,
                            input logic [15:0] step, input logic [15:0] count,
                            input logic [15:0] dwell, input logic [15:0] short_len,
                            input logic [15:0] half_len, input logic [15:0] long_len);
      csr_write(REG_FIXED_PERIOD, fixed);
      csr_write(REG_SWEEP_START, start);
      csr_write(REG_SWEEP_STEP, step);
      csr_write(REG_SWEEP_COUNT, count);
      csr_write(REG_SWEEP_DWELL, dwell);
      csr_write(REG_SHORT_TICKS, short_len);
      csr_write(REG_HALF_TICKS, half_len);
      csr_write(REG_LONG_TICKS, long_len);
      csr_wr_en <= 1'b0;
   endtask

   // drop valid, let the last beat land in the tracker, then wait out the pipeline
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_tones.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input int p);
      case (p)
         1: write_all(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h003F,
                      16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF);
         2: write_all(16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
         3: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
         default: write_all(16'($urandom),
                            (p == 4) ? 16'($urandom_range(0, 600)) :
                            (p == 5) ? 16'($urandom_range(64900, 65535)) : 16'($urandom),
                            16'($urandom),
                            {10'($urandom), 6'($urandom_range(1, 8))},
                            {5'($urandom), 11'($urandom_range(1, 12))},
                            {5'($urandom), 11'($urandom_range(1, 30))},
                            {5'($urandom), 11'($urandom_range(1, 30))},
                            {5'($urandom), 11'($urandom_range(1, 40))});
      endcase
   endtask

   task automatic directed_beats();
      logic [CMD_BITS-1:0] c;
      c = CMD_STOP;
      repeat (16) begin
         send_beat(1'b1, c);
         if (c <= CMD_LONG) send_beat(1'b0, ~c);
         c = c + 1'b1;
      end
   endtask

   // command followed by a run of ticks; short runs get stray commands mixed in
   task automatic random_sequences(input int budget);
      int                  sent;
      int                  n;
      int                  r;
      logic [CMD_BITS-1:0] cmd;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 9) == 0)
            cmd = CMD_BITS'($urandom_range(CMD_LONG + 1, {CMD_BITS{1'b1}}));
         else
            cmd = CMD_BITS'($urandom_range(CMD_STOP, CMD_LONG));
         send_beat(1'b1, cmd);
         r = $urandom_range(0, 99);
         if (r < 70)      n = $urandom_range(0, 30);
         else if (r < 96) n = $urandom_range(31, 120);
         else if (r < 99) n = $urandom_range(480, 620);
         else             n = $urandom_range(1500, 1560);
         if (n > budget - sent - 1) n = budget - sent - 1;
         repeat (n) begin
            if (n <= 120 && $urandom_range(0, 19) == 0)
               send_beat(1'b1, CMD_BITS'($urandom));
            else
               send_beat(1'b0, CMD_BITS'($urandom));
         end
         sent += n + 1;
      end
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            drain();
            apply_setting(p);
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 75;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 75;
            end
            default: begin
               send_idle_pct = 16;
               stall_pct     = 16;
            end
         endcase
         if (p == 0) directed_beats();
         random_sequences(150);
      end
      drain();
      if (tracker.mismatches == 0 && tracker.expected_tones.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/sts_pkg.sv
sv/sts_csr.sv
sv/sts_step.sv
sv/siren_tone_sequencer_unit.sv
tb/sts_tone_check_pkg.sv
tb/tb_siren_tone_sequencer_unit.sv
